FILE: src/huffman_code_table_bit_packer_core_assert.svh
// Assertion macros for the RTL of the code packer, included by hcbp_packer.sv.
`ifndef HUFFMAN_CODE_TABLE_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_CODE_TABLE_BIT_PACKER_CORE_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define HCBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define HCBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define HCBP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HCBP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/hcbp_pkg.sv
`default_nettype none

package hcbp_pkg;

    // Code table geometry.
    localparam int TBL_DEPTH = 256;
    localparam int ADDR_W    = 8;
    localparam int BITS_W    = 32;
    localparam int LEN_W     = 6;

    // Default for the longest code length that a load stores; longer ones saturate.
    localparam int MAX_CODE_LEN_DEF = 32;

    // Bit packer widths: one pending byte in front of a full code.
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 3;
    localparam int WIN_W  = BYTE_W + BITS_W;

    // Stream widths: tdata carries symbol, code bits and length, padded to bytes.
    localparam int CMD_W      = 2;
    localparam int S_FIELDS_W = ADDR_W + BITS_W + LEN_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    // Access to the code table.
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [BITS_W-1:0] bits;
        logic [LEN_W-1:0]  len;
    } t_tbl_req;

    // Registered read data; length reads as zero for never-loaded entries.
    typedef struct packed {
        logic [BITS_W-1:0] bits;
        logic [LEN_W-1:0]  len;
    } t_tbl_rsp;

endpackage

`default_nettype wire

FILE: src/hcbp_code_table.sv
`default_nettype none

module hcbp_code_table (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire hcbp_pkg::t_tbl_req  i_req,
    output hcbp_pkg::t_tbl_rsp       o_rsp
);
    import hcbp_pkg::*;

    logic [BITS_W-1:0]    r_bits_mem [TBL_DEPTH];
    logic [LEN_W-1:0]     r_len_mem  [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] r_valid;
    logic [BITS_W-1:0]    r_rd_bits;
    logic [LEN_W-1:0]     r_rd_len;
    logic                 r_rd_valid;

    // Code bits and lengths: one write and one read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_bits_mem[i_req.addr] <= i_req.bits;
            r_len_mem[i_req.addr]  <= i_req.len;
        end
        if (i_req.re) begin
            r_rd_bits <= r_bits_mem[i_req.addr];
            r_rd_len  <= r_len_mem[i_req.addr];
        end
    end

    // Valid bits stand in for the cleared length table after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_valid <= r_valid[i_req.addr];
            end
        end
    end

    assign o_rsp.bits = r_rd_bits;
    assign o_rsp.len  = r_rd_valid ? r_rd_len : '0;

endmodule

`default_nettype wire

FILE: src/hcbp_packer.sv
`default_nettype none

`include "huffman_code_table_bit_packer_core_assert.svh"

module hcbp_packer #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [hcbp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire  [hcbp_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [hcbp_pkg::BYTE_W-1:0]    m_axis_tdata,
    output logic                           m_axis_tlast,
    output hcbp_pkg::t_tbl_req             o_req,
    input  wire hcbp_pkg::t_tbl_rsp        i_rsp
);
    import hcbp_pkg::*;

    localparam int LEN_LIM_I = (MAX_CODE_LEN < BITS_W) ? MAX_CODE_LEN : BITS_W;
    localparam logic [LEN_W-1:0] LEN_LIM = LEN_W'(LEN_LIM_I);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [BYTE_W-1:0] r_part, n_part;
    logic [CNT_W-1:0]  r_pend, n_pend;
    logic [WIN_W-1:0]  r_sh, n_sh;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;

    logic              in_xfer;
    logic              out_free;
    logic [ADDR_W-1:0] in_sym;
    logic [BITS_W-1:0] in_bits;
    logic [LEN_W-1:0]  in_len;
    logic [LEN_W-1:0]  sat_len;
    logic [BITS_W-1:0] code_left;
    logic [WIN_W-1:0]  win;
    logic [LEN_W-1:0]  total;

    // Unpack the input transfer.
    assign in_sym  = s_axis_tdata[ADDR_W-1:0];
    assign in_bits = s_axis_tdata[ADDR_W +: BITS_W];
    assign in_len  = s_axis_tdata[ADDR_W+BITS_W +: LEN_W];
    assign sat_len = (in_len > LEN_LIM) ? LEN_LIM : in_len;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Table access: loads write, encodes read.
    always_comb begin
        o_req.we   = in_xfer && (s_axis_tuser == CMD_LOAD);
        o_req.re   = in_xfer && (s_axis_tuser == CMD_ENCODE);
        o_req.addr = in_sym;
        o_req.bits = in_bits;
        o_req.len  = sat_len;
    end

    // Append the looked-up code behind the pending bits, first bit highest.
    assign code_left = i_rsp.bits << (LEN_W'(BITS_W) - i_rsp.len);
    assign win   = {r_part, {BITS_W{1'b0}}} | ({code_left, {BYTE_W{1'b0}}} >> r_pend);
    assign total = {{(LEN_W-CNT_W){1'b0}}, r_pend} + i_rsp.len;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_part      = r_part;
        n_pend      = r_pend;
        n_sh        = r_sh;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && (s_axis_tuser == CMD_ENCODE)) begin
                    n_state = ST_LOOKUP;
                end else if (in_xfer && (s_axis_tuser == CMD_FLUSH)) begin
                    if (r_pend != '0) begin
                        n_sh    = {r_part, {BITS_W{1'b0}}};
                        n_cnt   = CNT_W'(1);
                        n_state = ST_EMIT;
                    end
                    n_part = '0;
                    n_pend = '0;
                end
            end
            ST_LOOKUP: begin
                n_pend = total[CNT_W-1:0];
                if (total[LEN_W-1:CNT_W] == '0) begin
                    n_part  = win[WIN_W-1 -: BYTE_W];
                    n_state = ST_IDLE;
                end else begin
                    n_sh    = win;
                    n_cnt   = total[LEN_W-1:CNT_W];
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_sh[WIN_W-1 -: BYTE_W];
                    n_out_last  = (r_cnt == CNT_W'(1));
                    n_sh        = r_sh << BYTE_W;
                    n_cnt       = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_part  = r_sh[WIN_W-BYTE_W-1 -: BYTE_W];
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and packer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_part      <= '0;
            r_pend      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_part      <= n_part;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Byte window and output register.
    always_ff @(posedge i_clk) begin
        r_sh       <= n_sh;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

    // A lookup ends in the next cycle, and emission always has bytes left.
    `HCBP_ASSERT_NXT(a_lookup_one_cycle, i_clk, i_rst_n, r_state == ST_LOOKUP, r_state != ST_LOOKUP)
    `HCBP_ASSERT_IMP(a_emit_count, i_clk, i_rst_n, r_state == ST_EMIT, (r_cnt != '0) && (r_cnt <= CNT_W'(4)))
    `HCBP_ASSERT_NXT(a_flush_clears, i_clk, i_rst_n, in_xfer && (s_axis_tuser == CMD_FLUSH), r_pend == '0)
    `HCBP_ASSERT_IMP(a_table_port, i_clk, i_rst_n, o_req.we, !o_req.re)

endmodule

`default_nettype wire

FILE: src/huffman_code_table_bit_packer_core.sv
`default_nettype none

// Channel   Dir  Bits  Contents
// s_axis    in   48    tdata: symbol[7:0], code bits[39:8], code length[45:40]; tuser: cmd
// m_axis    out  8     tdata: packed byte; tlast: last byte of this item
//
// A load writes its table entry as it is accepted. An encode reads the table, then
// merges the code into the pending bits, then emits each completed byte (up to
// four) as the output takes it. A flush with pending bits emits the partial byte.
// Synchronous active-low reset clears the packer and the table valid bits; no
// clearing pass. A stalled output holds the byte emitter; input waits meanwhile.

module huffman_code_table_bit_packer_core #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: symbol (8), new_code_bits (32), new_code_length (6), zero pad (2).
    input  wire  [hcbp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: cmd (2).
    input  wire  [hcbp_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // Fields from bit 0: packed_byte (8).
    output logic [hcbp_pkg::BYTE_W-1:0]    m_axis_tdata,
    output logic                           m_axis_tlast
);
    import hcbp_pkg::*;

    t_tbl_req tbl_req;
    t_tbl_rsp tbl_rsp;

    hcbp_code_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rsp   (tbl_rsp)
    );

    hcbp_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_req         (tbl_req),
        .i_rsp         (tbl_rsp)
    );

endmodule

`default_nettype wire

FILE: bench/tb_huffman_code_table_bit_packer_core.sv
`timescale 1ns / 1ps

module tb_huffman_code_table_bit_packer_core;

    import hcbp_pkg::*;

    // The command code that the block ignores.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // Loaded lengths saturate at the smaller of the parameter and the code width.
    localparam int LEN_CAP = (MAX_CODE_LEN_DEF < BITS_W) ? MAX_CODE_LEN_DEF : BITS_W;

    localparam int RANDOM_ITEMS   = 500;
    localparam int TAIL_ITEMS     = 40;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 120;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 1000;

    // One command as offered on the input stream.
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] sym;
        logic [BITS_W-1:0] bits;
        logic [LEN_W-1:0]  len;
        bit                wait_drain;
    } packer_item_t;

    // One byte expected on the output stream.
    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } packed_byte_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // Fields from bit 0: symbol (8), new_code_bits (32), new_code_length (6), zero pad (2).
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // Fields from bit 0: cmd (2).
    logic [CMD_W-1:0]     s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // Fields from bit 0: packed_byte (8).
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;

    huffman_code_table_bit_packer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    packer_item_t item_q[$];
    packed_byte_t byte_q[$];
    packer_item_t live_item;

    // Shadow copy of the code table and the bit packer.
    logic [BITS_W-1:0] code_word_mem [TBL_DEPTH];
    logic [LEN_W-1:0]  code_len_mem  [TBL_DEPTH];
    logic [BYTE_W-1:0] pend_byte = '0;
    int                pend_cnt = 0;

    int   n_items = 0;
    int   n_accepted = 0;
    int   n_errors = 0;
    int   stall_cycles = 0;
    int   src_gap = 0;
    int   sink_gap = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic tail_calm = 1'b0;
    logic may_idle;

    // Idling is switched off for one block of items in four and for the tail of the run.
    assign may_idle = !tail_calm && ((n_accepted / 64) % 4 != 3);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Work out the bytes that one accepted command produces.
    function automatic void pack_item(input packer_item_t it);
        logic [BITS_W-1:0] code;
        logic [BYTE_W-1:0] done_bytes [4];
        int                clen;
        int                n;
        packed_byte_t      pb;
        n = 0;
        case (it.cmd)
            CMD_LOAD: begin
                code_word_mem[it.sym] = it.bits;
                code_len_mem[it.sym] = (it.len > LEN_CAP) ? LEN_W'(LEN_CAP) : it.len;
            end
            CMD_ENCODE: begin
                code = code_word_mem[it.sym];
                clen = int'(code_len_mem[it.sym]);
                // The first code bit sits at the top of the valid length.
                for (int i = clen - 1; i >= 0; i--) begin
                    pend_byte[7 - pend_cnt] = code[i];
                    pend_cnt++;
                    if (pend_cnt == BYTE_W) begin
                        done_bytes[n] = pend_byte;
                        n++;
                        pend_byte = '0;
                        pend_cnt = 0;
                    end
                end
                for (int k = 0; k < n; k++) begin
                    pb.value = done_bytes[k];
                    pb.last = (k == n - 1);
                    byte_q.push_back(pb);
                end
            end
            CMD_FLUSH: begin
                if (pend_cnt != 0) begin
                    pb.value = pend_byte;
                    pb.last = 1'b1;
                    byte_q.push_back(pb);
                end
                pend_byte = '0;
                pend_cnt = 0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void queue_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] sym,
                                       input logic [BITS_W-1:0] bits, input logic [LEN_W-1:0] len,
                                       input bit wait_drain);
        packer_item_t it;
        it.cmd = cmd;
        it.sym = sym;
        it.bits = bits;
        it.len = len;
        it.wait_drain = wait_drain;
        item_q.push_back(it);
    endfunction

    // Input driver: offers queued commands, with random gaps between transfers.
    // A command marked to wait is held back until every expected byte has come.
    always @(posedge i_clk) begin
        packer_item_t nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pack_item(live_item);
                n_accepted <= n_accepted + 1;
            end
            tail_calm <= (item_q.size() <= TAIL_ITEMS);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (may_idle && $urandom_range(0, 4) == 0) begin
                    src_gap <= $urandom_range(0, 6);
                    s_axis_tvalid <= 1'b0;
                end else if (item_q.size() != 0
                             && !(item_q[0].wait_drain && byte_q.size() != 0)) begin
                    nxt = item_q.pop_front();
                    live_item <= nxt;
                    s_axis_tdata <= {2'b00, nxt.len, nxt.bits, nxt.sym};
                    s_axis_tuser <= nxt.cmd;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each transfer against the oldest expected byte.
    // Expectations are queued before their byte can appear.
    always @(posedge i_clk) begin
        packed_byte_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (byte_q.size() == 0) begin
                    $error("unexpected byte: packed_byte %02h, run_end %0b",
                           m_axis_tdata, m_axis_tlast);
                    n_errors++;
                end else begin
                    want = byte_q.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        $error("packed_byte mismatch: expected %02h, got %02h",
                               want.value, m_axis_tdata);
                        n_errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("run_end mismatch: expected %0b, got %0b",
                               want.last, m_axis_tlast);
                        n_errors++;
                    end
                end
            end
            // One long hold-off lets the block fill up and stall its input.
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (may_idle && $urandom_range(0, 5) == 0) begin
                sink_gap <= $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Count cycles without any transfer on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [ADDR_W-1:0] loaded_syms[$];
        logic [ADDR_W-1:0] sym;
        logic [LEN_W-1:0]  len;
        int                n_random;
        int                r;
        int                k;
        bit                drain;

        for (int i = 0; i < TBL_DEPTH; i++) begin
            code_word_mem[i] = '0;
            code_len_mem[i] = '0;
        end

        // Directed part: empty table, empty flush, the ignored command,
        // length extremes and saturation, bits above the length, and a
        // full code on top of seven pending bits.
        queue_item(CMD_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);
        queue_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
        queue_item(CMD_SPARE, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b0);
        queue_item(CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b0);
        queue_item(CMD_LOAD, 8'h00, 32'h0000_0000, 6'd63, 1'b0);
        queue_item(CMD_LOAD, 8'h01, 32'h0000_0001, 6'd1, 1'b0);
        queue_item(CMD_LOAD, 8'h80, 32'hA5A5_A5A5, 6'd33, 1'b0);
        queue_item(CMD_LOAD, 8'h7F, 32'h0000_0003, 6'd0, 1'b0);
        queue_item(CMD_LOAD, 8'h40, 32'hFFFF_FF5A, 6'd7, 1'b0);
        queue_item(CMD_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
        queue_item(CMD_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0);
        queue_item(CMD_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);
        queue_item(CMD_ENCODE, 8'h80, 32'h0, 6'd0, 1'b0);
        queue_item(CMD_ENCODE, 8'h7F, 32'h0, 6'd0, 1'b0);
        queue_item(CMD_ENCODE, 8'h40, 32'h0, 6'd0, 1'b0);
        queue_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
        queue_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
        for (int i = 0; i < 7; i++) begin
            queue_item(CMD_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0);
        end
        queue_item(CMD_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
        queue_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
        loaded_syms = '{8'hFF, 8'h00, 8'h01, 8'h80, 8'h40};

        // Random part: mostly encodes of loaded symbols, with loads and
        // flushes in between and a few ignored commands as noise.
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            drain = (n_random == 0) || (n_random == 300);
            r = $urandom_range(0, 99);
            sym = ADDR_W'($urandom_range(0, 255));
            if (r < 15) begin
                k = $urandom_range(0, 9);
                if (k == 0) begin
                    len = 6'd0;
                end else if (k == 1) begin
                    len = LEN_W'($urandom_range(33, 63));
                end else if (k < 4) begin
                    len = LEN_W'($urandom_range(1, 4));
                end else begin
                    len = LEN_W'($urandom_range(1, 32));
                end
                if (len != 0) begin
                    loaded_syms.push_back(sym);
                end
                queue_item(CMD_LOAD, sym, $urandom, len, drain);
                n_random++;
            end else if (r < 87) begin
                if (loaded_syms.size() != 0 && $urandom_range(0, 9) != 0) begin
                    sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
                end
                queue_item(CMD_ENCODE, sym, $urandom, LEN_W'($urandom_range(0, 63)), drain);
                n_random++;
            end else if (r < 97) begin
                queue_item(CMD_FLUSH, sym, $urandom, LEN_W'($urandom_range(0, 63)), drain);
                n_random++;
            end else begin
                queue_item(CMD_SPARE, sym, $urandom, LEN_W'($urandom_range(0, 63)), drain);
            end
        end
        queue_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
        n_items = item_q.size();

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every command to be accepted, then for every byte.
        while (n_accepted != n_items) @(posedge i_clk);
        while (byte_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
